### rtl/wsfd_pkg.sv
`timescale 1ns / 1ps

package wsfd_pkg;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_MASK = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       frame_end;
        logic       close_seen;
    } result_t;

endpackage

### rtl/wsfd_byte_if.sv
`timescale 1ns / 1ps

interface wsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/wsfd_result_if.sv
`timescale 1ns / 1ps

interface wsfd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       frame_end;
    logic       close_seen;

    modport source (
        output valid, output data_byte, output has_data, output frame_opcode,
        output final_fragment, output frame_end, output close_seen,
        input ready
    );
    modport sink (
        input valid, input data_byte, input has_data, input frame_opcode,
        input final_fragment, input frame_end, input close_seen,
        output ready
    );
endinterface

### rtl/websocket_frame_decoder_core.sv
`timescale 1ns / 1ps
// channel  dir  modport                 word
// stream   in   wsfd_byte_if.sink       rx_byte, one framed stream byte
// result   out  wsfd_result_if.source   data_byte, has_data, frame_opcode,
//                                       final_fragment, frame_end, close_seen
//
// One byte per cycle unless a held result stalls the input; an accepted byte goes
// to the input register, then through the parse logic into the result register.
// rst_n clears the parse state: first header byte expected, stream open.
// A held result stalls the input register only when that byte yields a result.
// After a close frame ends, bytes are still taken and dropped until reset.

module websocket_frame_decoder_core
    import wsfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    wsfd_byte_if.sink      stream,
    wsfd_result_if.source  result
);

    logic       advance;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       res_valid;
    result_t    res;
    logic       can_take;
    logic       load;

    assign advance = byte_valid && (!res_valid || can_take);
    assign load    = advance && res_valid;

    wsfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .advance    (advance),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    wsfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsfd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .can_take (can_take),
        .result   (result)
    );

endmodule

### rtl/wsfd_in_stage.sv
`timescale 1ns / 1ps

module wsfd_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    wsfd_byte_if.sink    stream,
    input  logic         advance,
    output logic         byte_valid,
    output logic [7:0]   rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign stream.ready = !valid_reg || advance;
    assign valid_next   = stream.ready ? stream.valid : valid_reg;
    assign byte_valid   = valid_reg;
    assign rx_byte      = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            byte_reg <= stream.rx_byte;
        end
    end

endmodule

### rtl/wsfd_parser.sv
`timescale 1ns / 1ps

module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       res_valid,
    output result_t    res
);

    phase_t           phase_reg, phase_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             mask_present_reg, mask_present_next;
    logic [3:0]       ext_left_reg, ext_left_next;
    logic [3:0][7:0]  mask_key_reg, mask_key_next;
    logic [63:0]      payload_left_reg, payload_left_next;
    logic [1:0]       key_index_reg, key_index_next;
    logic             closed_reg, closed_next;

    logic             len_done;
    logic             hdr_done;
    logic             emit;
    logic             emit_has;
    logic             emit_end;
    logic [7:0]       emit_data;
    logic             close_now;

    always_comb
    begin
        phase_next        = phase_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        mask_present_next = mask_present_reg;
        ext_left_next     = ext_left_reg;
        mask_key_next     = mask_key_reg;
        payload_left_next = payload_left_reg;
        key_index_next    = key_index_reg;
        len_done          = 1'b0;
        hdr_done          = 1'b0;
        emit              = 1'b0;
        emit_has          = 1'b0;
        emit_end          = 1'b0;
        emit_data         = '0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                mask_present_next = rx_byte[7];
                mask_key_next     = '0;
                payload_left_next = '0;
                if (rx_byte[6:0] == LEN_EXT16)
                begin
                    ext_left_next = EXT16_BYTES;
                    phase_next    = PH_EXT;
                end
                else if (rx_byte[6:0] == LEN_EXT64)
                begin
                    ext_left_next = EXT64_BYTES;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    payload_left_next = {57'd0, rx_byte[6:0]};
                    len_done          = 1'b1;
                end
            end
            PH_EXT:
            begin
                payload_left_next = {payload_left_reg[55:0], rx_byte};
                ext_left_next     = ext_left_reg - 4'd1;
                len_done          = (ext_left_next == 4'd0);
            end
            PH_MASK:
            begin
                mask_key_next[~key_index_reg] = rx_byte;
                key_index_next                = key_index_reg + 2'd1;
                hdr_done                      = (key_index_next == 2'd0);
            end
            PH_DATA:
            begin
                emit              = 1'b1;
                emit_has          = 1'b1;
                emit_data         = rx_byte ^ mask_key_reg[~key_index_reg];
                key_index_next    = key_index_reg + 2'd1;
                payload_left_next = payload_left_reg - 64'd1;
                if (payload_left_next == 64'd0)
                begin
                    emit_end   = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HDR1;
            end
        endcase

        if (len_done)
        begin
            if (mask_present_next)
            begin
                key_index_next = 2'd0;
                phase_next     = PH_MASK;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        // empty frame: end mark rides on the last header word
        if (hdr_done)
        begin
            key_index_next = 2'd0;
            if (payload_left_next == 64'd0)
            begin
                phase_next = PH_HDR0;
                emit       = 1'b1;
                emit_end   = 1'b1;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    assign close_now   = emit_end && (opcode_reg == OP_CLOSE);
    assign closed_next = closed_reg || close_now;
    assign res_valid   = byte_valid && !closed_reg && emit;

    assign res.data_byte      = emit_data;
    assign res.has_data       = emit_has;
    assign res.frame_opcode   = opcode_reg;
    assign res.final_fragment = fin_reg;
    assign res.frame_end      = emit_end;
    assign res.close_seen     = close_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR0;
            fin_reg          <= 1'b0;
            opcode_reg       <= '0;
            mask_present_reg <= 1'b0;
            ext_left_reg     <= '0;
            mask_key_reg     <= '0;
            payload_left_reg <= '0;
            key_index_reg    <= '0;
            closed_reg       <= 1'b0;
        end
        else if (advance && !closed_reg)
        begin
            phase_reg        <= phase_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            mask_present_reg <= mask_present_next;
            ext_left_reg     <= ext_left_next;
            mask_key_reg     <= mask_key_next;
            payload_left_reg <= payload_left_next;
            key_index_reg    <= key_index_next;
            closed_reg       <= closed_next;
        end
    end

    a_close_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.close_seen |-> res.frame_end)
        else $error("close flagged off frame end");

    a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> !res_valid)
        else $error("result after stream closed");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.has_data |-> res.frame_end && res.data_byte == 8'd0)
        else $error("dataless result not an empty frame end");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> payload_left_reg != 64'd0)
        else $error("payload phase with zero count");

endmodule

### rtl/wsfd_out_reg.sv
`timescale 1ns / 1ps

module wsfd_out_reg
    import wsfd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  result_t         res,
    output logic            can_take,
    wsfd_result_if.source   result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_take   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    assign result.valid          = valid_reg;
    assign result.data_byte      = data_reg.data_byte;
    assign result.has_data       = data_reg.has_data;
    assign result.frame_opcode   = data_reg.frame_opcode;
    assign result.final_fragment = data_reg.final_fragment;
    assign result.frame_end      = data_reg.frame_end;
    assign result.close_seen     = data_reg.close_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule
